@@ src/acld_pkg.sv @@
// Shared types, codes and command word table for the ASCII command line decoder.
package acld_pkg;

    localparam int LINE_CAPACITY_DEF = 64;

    localparam int ByteW  = 8;
    localparam int KindW  = 4;
    localparam int TestW  = 3;
    localparam int PulseW = 20;
    localparam int AccW   = 32;

    // Result kinds as seen on the output channel.
    localparam logic [KindW-1:0] K_PING        = 4'd0;
    localparam logic [KindW-1:0] K_STATUS      = 4'd1;
    localparam logic [KindW-1:0] K_CLEAR       = 4'd2;
    localparam logic [KindW-1:0] K_RUN         = 4'd3;
    localparam logic [KindW-1:0] K_HELP        = 4'd4;
    localparam logic [KindW-1:0] K_BAD_COMMAND = 4'd5;
    localparam logic [KindW-1:0] K_TOO_LONG    = 4'd6;
    localparam logic [KindW-1:0] K_BAD_ID      = 4'd7;
    localparam logic [KindW-1:0] K_ID_RANGE    = 4'd8;
    localparam logic [KindW-1:0] K_BAD_PULSE   = 4'd9;
    localparam logic [KindW-1:0] K_PULSE_RANGE = 4'd10;

    localparam logic [TestW-1:0] TEST_MIN = 3'd1;
    localparam logic [TestW-1:0] TEST_MAX = 3'd6;

    // Command word indexes; the first match wins when several are complete.
    localparam int NumWords = 5;
    localparam logic [2:0] WORD_PING   = 3'd0;
    localparam logic [2:0] WORD_STATUS = 3'd1;
    localparam logic [2:0] WORD_CLEAR  = 3'd2;
    localparam logic [2:0] WORD_RUN    = 3'd3;
    localparam logic [2:0] WORD_HELP   = 3'd4;
    localparam logic [2:0] WORD_NONE   = 3'd5;

    typedef struct packed {
        logic              valid;
        logic [KindW-1:0]  kind;
        logic [TestW-1:0]  test;
        logic [PulseW-1:0] pulse;
    } t_result;

    // Upper-case text of a command word; byte 0 is the first character.
    function automatic logic [7:0] word_char(input logic [2:0] w, input logic [2:0] col);
        logic [7:0][7:0] text;
        begin
            case (w)
                WORD_PING:   text = {8'h00, 8'h00, 8'h00, 8'h00, "G", "N", "I", "P"};
                WORD_STATUS: text = {8'h00, 8'h00, "S", "U", "T", "A", "T", "S"};
                WORD_CLEAR:  text = {8'h00, 8'h00, 8'h00, "R", "A", "E", "L", "C"};
                WORD_RUN:    text = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "N", "U", "R"};
                WORD_HELP:   text = {8'h00, 8'h00, 8'h00, 8'h00, "P", "L", "E", "H"};
                default:     text = '0;
            endcase
            return text[col];
        end
    endfunction

    function automatic logic [2:0] word_len(input logic [2:0] w);
        case (w)
            WORD_PING:   return 3'd4;
            WORD_STATUS: return 3'd6;
            WORD_CLEAR:  return 3'd5;
            WORD_RUN:    return 3'd3;
            WORD_HELP:   return 3'd4;
            default:     return 3'd0;
        endcase
    endfunction

    function automatic logic [KindW-1:0] word_kind(input logic [2:0] w);
        case (w)
            WORD_PING:   return K_PING;
            WORD_STATUS: return K_STATUS;
            WORD_CLEAR:  return K_CLEAR;
            WORD_RUN:    return K_RUN;
            WORD_HELP:   return K_HELP;
            default:     return K_BAD_COMMAND;
        endcase
    endfunction

endpackage

@@ src/acld_parser.sv @@
// Per-byte line parser: line state registers and their single-pass next-state logic.
module acld_parser #(
    parameter int LINE_CAPACITY = acld_pkg::LINE_CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [acld_pkg::ByteW-1:0] i_byte,
    output acld_pkg::t_result         o_result
);
    import acld_pkg::*;

    localparam int CountW = $clog2(LINE_CAPACITY);
    localparam logic [CountW-1:0] LastCount = CountW'(LINE_CAPACITY - 1);

    localparam logic [3:0] PH_LEAD      = 4'd0;
    localparam logic [3:0] PH_WORD      = 4'd1;
    localparam logic [3:0] PH_TAIL      = 4'd2;
    localparam logic [3:0] PH_ID_START  = 4'd3;
    localparam logic [3:0] PH_ID_ZERO   = 4'd4;
    localparam logic [3:0] PH_ID_DIGITS = 4'd5;
    localparam logic [3:0] PH_AFTER_ID  = 4'd6;
    localparam logic [3:0] PH_P_ZERO    = 4'd7;
    localparam logic [3:0] PH_P_DIGITS  = 4'd8;
    localparam logic [3:0] PH_P_TAIL    = 4'd9;
    localparam logic [3:0] PH_FAULT     = 4'd10;

    localparam logic [ByteW-1:0] ChCr    = 8'd13;
    localparam logic [ByteW-1:0] ChLf    = 8'd10;
    localparam logic [ByteW-1:0] ChSpace = 8'd32;
    localparam logic [ByteW-1:0] ChTab   = 8'd9;
    localparam logic [ByteW-1:0] ChNul   = 8'd0;
    localparam logic [ByteW-1:0] ChZero  = 8'd48;
    localparam logic [ByteW-1:0] ChLowX  = 8'd120;
    localparam logic [ByteW-1:0] ChUpX   = 8'd88;

    localparam logic [AccW-1:0] DecLimit   = 32'd429496729;
    localparam logic [AccW-1:0] HexLimit   = 32'h0FFF_FFFF;
    localparam logic [AccW-1:0] PulseMax   = 32'h000F_FFFF;
    localparam logic [AccW-1:0] PulseReset = 32'd10;

    logic [CountW-1:0] r_count, n_count;
    logic              r_too_long, n_too_long;
    logic              r_text_ended, n_text_ended;
    logic [3:0]        r_phase, n_phase;
    logic [2:0]        r_col, n_col;
    logic [NumWords-1:0] r_match, n_match;
    logic [AccW-1:0]   r_acc, n_acc;
    logic              r_ds, n_ds;
    logic              r_hex, n_hex;
    logic [TestW-1:0]  r_id, n_id;
    logic [AccW-1:0]   r_pulse, n_pulse;
    logic [KindW-1:0]  r_fault, n_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_too_long   <= 1'b0;
            r_text_ended <= 1'b0;
            r_phase      <= PH_LEAD;
            r_col        <= '0;
            r_match      <= '1;
            r_acc        <= '0;
            r_ds         <= 1'b0;
            r_hex        <= 1'b0;
            r_id         <= '0;
            r_pulse      <= PulseReset;
            r_fault      <= '0;
        end else if (i_step) begin
            r_count      <= n_count;
            r_too_long   <= n_too_long;
            r_text_ended <= n_text_ended;
            r_phase      <= n_phase;
            r_col        <= n_col;
            r_match      <= n_match;
            r_acc        <= n_acc;
            r_ds         <= n_ds;
            r_hex        <= n_hex;
            r_id         <= n_id;
            r_pulse      <= n_pulse;
            r_fault      <= n_fault;
        end
    end

    always_comb begin
        logic             is_sp;
        logic [7:0]       up;
        logic [4:0]       dig;
        logic [2:0]       mw;
        logic             num_pulse;
        logic [AccW-1:0]  eff_acc;
        logic             eff_hex;
        logic             eff_ds;
        logic             dvalid;
        logic             ovf;
        logic [AccW-1:0]  acc_dig;
        logic             do_num;
        logic             fin_valid;
        logic             run_check;
        logic [KindW-1:0] fin_kind;
        logic [TestW-1:0] fin_id;
        logic [AccW-1:0]  fin_p;

        n_count      = r_count;
        n_too_long   = r_too_long;
        n_text_ended = r_text_ended;
        n_phase      = r_phase;
        n_col        = r_col;
        n_match      = r_match;
        n_acc        = r_acc;
        n_ds         = r_ds;
        n_hex        = r_hex;
        n_id         = r_id;
        n_pulse      = r_pulse;
        n_fault      = r_fault;
        o_result     = '0;
        do_num       = 1'b0;

        is_sp = (i_byte == ChSpace) || (i_byte == ChTab);
        up = (i_byte >= 8'd97 && i_byte <= 8'd122) ? i_byte - 8'd32 : i_byte;
        if (i_byte >= 8'd48 && i_byte <= 8'd57) begin
            dig = {1'b0, i_byte[3:0]};
        end else if (up >= 8'd65 && up <= 8'd70) begin
            dig = 5'({1'b0, up[3:0]} + 5'd9);
        end else begin
            dig = 5'd16;
        end

        // First command word that is complete at the current column.
        mw = WORD_NONE;
        for (int w = NumWords - 1; w >= 0; w--) begin
            if (r_match[w] && r_col == word_len(3'(w))) begin
                mw = 3'(w);
            end
        end

        num_pulse = (r_phase == PH_AFTER_ID) || (r_phase == PH_P_ZERO) ||
                    (r_phase == PH_P_DIGITS);

        // Number context the digit step works on for this byte.
        eff_acc = '0;
        eff_hex = 1'b0;
        eff_ds  = 1'b0;
        if (r_phase == PH_ID_DIGITS || r_phase == PH_P_DIGITS) begin
            eff_acc = r_acc;
            eff_hex = r_hex;
            eff_ds  = r_ds;
        end else if (r_phase == PH_ID_ZERO || r_phase == PH_P_ZERO) begin
            eff_ds = 1'b1;
        end

        dvalid = eff_hex ? (dig < 5'd16) : (dig < 5'd10);
        if (eff_hex) begin
            ovf     = eff_acc > HexLimit;
            acc_dig = {eff_acc[AccW-5:0], dig[3:0]};
        end else begin
            ovf     = (eff_acc > DecLimit) || (eff_acc == DecLimit && dig > 5'd5);
            acc_dig = {eff_acc[AccW-4:0], 3'b000} + {eff_acc[AccW-2:0], 1'b0} +
                      {28'd0, dig[3:0]};
        end

        // Outcome of the line if it ended now.
        fin_valid = 1'b1;
        run_check = 1'b0;
        fin_kind  = r_fault;
        fin_id    = r_id;
        fin_p     = r_pulse;
        case (r_phase)
            PH_LEAD:     fin_valid = 1'b0;
            PH_WORD:     fin_kind = (mw == WORD_RUN) ? K_BAD_ID : word_kind(mw);
            PH_TAIL:     fin_kind = word_kind(mw);
            PH_ID_START: fin_kind = K_BAD_ID;
            PH_ID_ZERO:  fin_kind = K_ID_RANGE;
            PH_ID_DIGITS: begin
                if (!r_ds) begin
                    fin_kind = K_BAD_ID;
                end else if (r_acc == '0 || r_acc > AccW'(TEST_MAX)) begin
                    fin_kind = K_ID_RANGE;
                end else begin
                    fin_id    = r_acc[TestW-1:0];
                    run_check = 1'b1;
                end
            end
            PH_AFTER_ID: run_check = 1'b1;
            PH_P_ZERO:   fin_kind = K_PULSE_RANGE;
            PH_P_DIGITS: begin
                if (!r_ds) begin
                    fin_kind = K_BAD_PULSE;
                end else begin
                    fin_p     = r_acc;
                    run_check = 1'b1;
                end
            end
            PH_P_TAIL:   run_check = 1'b1;
            default:     fin_kind = r_fault;
        endcase
        if (run_check) begin
            fin_kind = (fin_p == '0 || fin_p > PulseMax) ? K_PULSE_RANGE : K_RUN;
        end

        if (i_byte == ChCr || i_byte == ChLf) begin
            if (r_too_long) begin
                o_result.valid = 1'b1;
                o_result.kind  = K_TOO_LONG;
            end else if (r_count != '0 && fin_valid) begin
                o_result.valid = 1'b1;
                o_result.kind  = fin_kind;
                if (fin_kind == K_RUN) begin
                    o_result.test  = fin_id;
                    o_result.pulse = fin_p[PulseW-1:0];
                end
            end
            n_count      = '0;
            n_too_long   = 1'b0;
            n_text_ended = 1'b0;
            n_phase      = PH_LEAD;
            n_col        = '0;
            n_match      = '1;
            n_acc        = '0;
            n_ds         = 1'b0;
            n_hex        = 1'b0;
            n_id         = '0;
            n_pulse      = PulseReset;
            n_fault      = '0;
        end else if (!r_too_long) begin
            if (r_count != LastCount) begin
                n_count      = r_count + 1'b1;
                n_text_ended = r_text_ended || (i_byte == ChNul);
                if (!n_text_ended) begin
                    case (r_phase)
                        PH_LEAD, PH_WORD: begin
                            if (is_sp) begin
                                if (r_phase == PH_WORD) begin
                                    if (mw == WORD_NONE) begin
                                        n_fault = K_BAD_COMMAND;
                                        n_phase = PH_FAULT;
                                    end else begin
                                        n_match = NumWords'(1) << mw;
                                        n_phase = (mw == WORD_RUN) ? PH_ID_START : PH_TAIL;
                                    end
                                end
                            end else begin
                                n_phase = PH_WORD;
                                for (int w = 0; w < NumWords; w++) begin
                                    if (r_col >= word_len(3'(w)) ||
                                        up != word_char(3'(w), r_col)) begin
                                        n_match[w] = 1'b0;
                                    end
                                end
                                if (r_col != 3'd7) begin
                                    n_col = r_col + 3'd1;
                                end
                            end
                        end
                        PH_TAIL: begin
                            if (!is_sp) begin
                                n_fault = K_BAD_COMMAND;
                                n_phase = PH_FAULT;
                            end
                        end
                        PH_ID_START, PH_AFTER_ID: begin
                            if (!is_sp) begin
                                n_acc = '0;
                                n_hex = 1'b0;
                                n_ds  = 1'b0;
                                if (i_byte == ChZero) begin
                                    n_phase = num_pulse ? PH_P_ZERO : PH_ID_ZERO;
                                end else begin
                                    n_phase = num_pulse ? PH_P_DIGITS : PH_ID_DIGITS;
                                    do_num  = 1'b1;
                                end
                            end
                        end
                        PH_ID_ZERO, PH_P_ZERO: begin
                            n_phase = num_pulse ? PH_P_DIGITS : PH_ID_DIGITS;
                            n_acc   = '0;
                            if (i_byte == ChLowX || i_byte == ChUpX) begin
                                n_hex = 1'b1;
                                n_ds  = 1'b0;
                            end else begin
                                n_hex  = 1'b0;
                                n_ds   = 1'b1;
                                do_num = 1'b1;
                            end
                        end
                        PH_ID_DIGITS, PH_P_DIGITS: do_num = 1'b1;
                        default: ;
                    endcase

                    if (do_num) begin
                        if (!dvalid) begin
                            // The number ends at this byte.
                            if (!num_pulse) begin
                                if (!eff_ds) begin
                                    n_fault = K_BAD_ID;
                                    n_phase = PH_FAULT;
                                end else if (eff_acc == '0 || eff_acc > AccW'(TEST_MAX)) begin
                                    n_fault = K_ID_RANGE;
                                    n_phase = PH_FAULT;
                                end else if (is_sp) begin
                                    n_id    = eff_acc[TestW-1:0];
                                    n_phase = PH_AFTER_ID;
                                end else begin
                                    // A non-digit glued to the id cannot start a pulse.
                                    n_fault = K_BAD_PULSE;
                                    n_phase = PH_FAULT;
                                end
                            end else begin
                                if (!eff_ds) begin
                                    n_fault = K_BAD_PULSE;
                                    n_phase = PH_FAULT;
                                end else begin
                                    n_pulse = eff_acc;
                                    if (is_sp) begin
                                        n_phase = PH_P_TAIL;
                                    end else begin
                                        n_fault = K_BAD_PULSE;
                                        n_phase = PH_FAULT;
                                    end
                                end
                            end
                        end else if (ovf) begin
                            n_fault = num_pulse ? K_BAD_PULSE : K_BAD_ID;
                            n_phase = PH_FAULT;
                        end else begin
                            n_acc = acc_dig;
                            n_ds  = 1'b1;
                        end
                    end
                end
            end else begin
                n_too_long = 1'b1;
            end
        end
    end

endmodule

@@ src/ascii_command_line_decoder.sv @@
// Top level of the ASCII command line decoder: input register, parser and result register.
//
// Usage: received bytes arrive on the input channel (i_valid, o_ready, i_rx_byte), one byte
// per beat. When a carriage return or line feed is taken, the decoded command for the line
// leaves on the output channel (o_valid, i_ready) as one beat carrying o_command_kind,
// o_test_number and o_pulse_cycles. A blank line, or any other byte, produces no beat.
//
// Timing: a terminator byte accepted into the input register is parsed into the result register
// when that register is free, and its result is presented on o_valid from then on. Throughput:
// one byte per cycle while no result beat is stalled. Each byte is parsed in a single
// combinational pass from the input register into the parser state and the result register.
//
// Reset (i_rst_n low, synchronous) empties both registers and returns the parser to the
// start of a fresh line.
//
// When the receiver holds i_ready low with a result waiting, the input register fills and
// o_ready drops until the result beat is taken; no byte or result is lost.
module ascii_command_line_decoder #(
    parameter int LINE_CAPACITY = acld_pkg::LINE_CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [acld_pkg::ByteW-1:0]  i_rx_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [acld_pkg::KindW-1:0]  o_command_kind,
    output logic [acld_pkg::TestW-1:0]  o_test_number,
    output logic [acld_pkg::PulseW-1:0] o_pulse_cycles
);
    import acld_pkg::*;

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_out_valid;
    logic [KindW-1:0] r_kind;
    logic [TestW-1:0] r_test;
    logic [PulseW-1:0] r_pulse;
    logic             advance;
    t_result          parse_result;

    // The held byte is parsed whenever the result register can take whatever it yields.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    acld_parser #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_result (parse_result)
    );

    // Result register: loaded on each parsed byte, cleared once its beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= parse_result.valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && parse_result.valid) begin
            r_kind  <= parse_result.kind;
            r_test  <= parse_result.test;
            r_pulse <= parse_result.pulse;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_command_kind = r_kind;
    assign o_test_number  = r_test;
    assign o_pulse_cycles = r_pulse;

endmodule

@@ src/acld_checker.sv @@
// Port-level assertions for the ASCII command line decoder, and the bind that attaches them.
module acld_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [acld_pkg::KindW-1:0]  o_command_kind,
    input logic [acld_pkg::TestW-1:0]  o_test_number,
    input logic [acld_pkg::PulseW-1:0] o_pulse_cycles
);
    import acld_pkg::*;

    // Every reported kind is a defined code.
    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_command_kind <= K_PULSE_RANGE))
        else $error("command kind out of range");

    // Only a run carries an id and a pulse width.
    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_command_kind != K_RUN) |-> (o_test_number == '0 && o_pulse_cycles == '0))
        else $error("data on a non-run result");

    // A run always has a legal id and a non-zero pulse.
    a_run_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_command_kind == K_RUN) |->
            (o_test_number >= TEST_MIN && o_test_number <= TEST_MAX && o_pulse_cycles != '0))
        else $error("run result with illegal data");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_command_kind) && $stable(o_test_number) &&
             $stable(o_pulse_cycles)))
        else $error("result beat changed while stalled");

    // The input is only held off by a result beat that the receiver is not taking.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without a waiting result");

endmodule

bind ascii_command_line_decoder acld_checker u_acld_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_command_kind (o_command_kind),
    .o_test_number  (o_test_number),
    .o_pulse_cycles (o_pulse_cycles)
);
